// ----- rtl/core/mmh_pkg.sv -----
`timescale 1ns / 1ps

package mmh_pkg;

	localparam logic [63:0] HASH_MUL  = 64'hc6a4a793_5bd1e995;
	localparam logic [31:0] MUL_LO    = HASH_MUL[31:0];
	localparam logic [31:0] MUL_HI    = HASH_MUL[63:32];
	localparam int          MIX_SHIFT = 47;

	localparam logic [2:0] OP_LEN  = 3'd0;
	localparam logic [2:0] OP_W1   = 3'd1;
	localparam logic [2:0] OP_W2   = 3'd2;
	localparam logic [2:0] OP_W3   = 3'd3;
	localparam logic [2:0] OP_TAIL = 3'd4;
	localparam logic [2:0] OP_FIN  = 3'd5;

	localparam logic [1:0] STEP_LO  = 2'd0;
	localparam logic [1:0] STEP_MID = 2'd1;
	localparam logic [1:0] STEP_TOP = 2'd2;

	typedef struct packed {
		logic       in_ready;
		logic       capture;
		logic       step_en;
		logic [1:0] step;
		logic [2:0] op;
	} mmh_cmd_t;

	typedef struct packed {
		logic accept;
		logic full_word;
		logic has_tail;
		logic last;
		logic out_busy;
	} mmh_status_t;

	function automatic logic [63:0] mix47(input logic [63:0] v);
		return v ^ (v >> MIX_SHIFT);
	endfunction

	function automatic logic [63:0] tail_mask(input logic [2:0] nbytes);
		logic [5:0] sh;
		sh = {nbytes, 3'b000};
		return (64'd1 << sh) - 64'd1;
	endfunction

endpackage

// ----- rtl/core/mmh_if.sv -----
`timescale 1ns / 1ps

interface mmh_in_if;
	logic        valid;
	logic        ready;
	logic [63:0] data_word;
	logic [3:0]  valid_bytes;
	logic [31:0] key_length;
	logic        last_word;

	modport source (output valid, data_word, valid_bytes, key_length, last_word, input ready);
	modport sink   (input valid, data_word, valid_bytes, key_length, last_word, output ready);
endinterface

interface mmh_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] hash_value;

	modport source (output valid, hash_value, input ready);
	modport sink   (input valid, hash_value, output ready);
endinterface

// ----- rtl/core/murmur2_64_byte_hash_core.sv -----
`timescale 1ns / 1ps
// One beat is taken per word; the next beat is taken once the word is done.
// Each word takes a control step, then its 64-bit products on the shared 32-bit
// multiplier: three for a full word, one for a partial word, none for an empty
// one; the first word of a key adds the length product, the last the finishing pass.
// The hash beat is registered and appears the cycle after the finishing pass.
// Asynchronous active-low reset clears the seed and running hash to zero.

module murmur2_64_byte_hash_core
	import mmh_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [63:0] cfg_wdata,
	mmh_in_if.sink      key_in,
	mmh_out_if.source   hash_out
);

	mmh_cmd_t    cmd;
	mmh_status_t status;

	mmh_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.cmd    (cmd)
	);

	mmh_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.status    (status),
		.key_in    (key_in),
		.hash_out  (hash_out)
	);

endmodule

// ----- rtl/core/mmh_ctrl.sv -----
`timescale 1ns / 1ps

module mmh_ctrl
	import mmh_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  mmh_status_t status,
	output mmh_cmd_t    cmd
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_LEN  = 3'd1;
	localparam logic [2:0] ST_NEXT = 3'd2;
	localparam logic [2:0] ST_W1   = 3'd3;
	localparam logic [2:0] ST_W2   = 3'd4;
	localparam logic [2:0] ST_W3   = 3'd5;
	localparam logic [2:0] ST_TAIL = 3'd6;
	localparam logic [2:0] ST_FIN  = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic [1:0] cnt_q;
	logic       first_q;
	logic       first_d;
	logic       mul_state;
	logic       run;
	logic [2:0] op_d;

	always_comb begin
		op_d      = OP_LEN;
		mul_state = 1'b1;
		unique case (state_q)
			ST_LEN:  op_d = OP_LEN;
			ST_W1:   op_d = OP_W1;
			ST_W2:   op_d = OP_W2;
			ST_W3:   op_d = OP_W3;
			ST_TAIL: op_d = OP_TAIL;
			ST_FIN:  op_d = OP_FIN;
			default: mul_state = 1'b0;
		endcase
	end

	// The finishing pass does not start while an earlier hash still waits.
	assign run = mul_state && !(state_q == ST_FIN && cnt_q == STEP_LO && status.out_busy);

	always_comb begin
		cmd.in_ready = (state_q == ST_IDLE);
		cmd.capture  = (state_q == ST_IDLE) && status.accept;
		cmd.step_en  = run;
		cmd.step     = cnt_q;
		cmd.op       = op_d;
	end

	always_comb begin
		state_d = state_q;
		first_d = first_q;
		unique case (state_q)
			ST_IDLE: begin
				if (status.accept) begin
					state_d = first_q ? ST_LEN : ST_NEXT;
				end
			end
			ST_LEN: begin
				if (run && cnt_q == STEP_TOP) begin
					state_d = ST_NEXT;
				end
			end
			ST_NEXT: begin
				if (status.full_word) begin
					state_d = ST_W1;
				end else if (status.has_tail) begin
					state_d = ST_TAIL;
				end else if (status.last) begin
					state_d = ST_FIN;
				end else begin
					state_d = ST_IDLE;
					first_d = 1'b0;
				end
			end
			ST_W1: begin
				if (run && cnt_q == STEP_TOP) begin
					state_d = ST_W2;
				end
			end
			ST_W2: begin
				if (run && cnt_q == STEP_TOP) begin
					state_d = ST_W3;
				end
			end
			ST_W3, ST_TAIL: begin
				if (run && cnt_q == STEP_TOP) begin
					if (status.last) begin
						state_d = ST_FIN;
					end else begin
						state_d = ST_IDLE;
						first_d = 1'b0;
					end
				end
			end
			ST_FIN: begin
				if (run && cnt_q == STEP_TOP) begin
					state_d = ST_IDLE;
					first_d = 1'b1;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= STEP_LO;
			first_q <= 1'b1;
		end else begin
			state_q <= state_d;
			first_q <= first_d;
			if (run) begin
				cnt_q <= (cnt_q == STEP_TOP) ? STEP_LO : cnt_q + 2'd1;
			end
		end
	end

endmodule

// ----- rtl/core/mmh_datapath.sv -----
`timescale 1ns / 1ps

module mmh_datapath
	import mmh_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [63:0]  cfg_wdata,
	input  mmh_cmd_t     cmd,
	output mmh_status_t  status,
	mmh_in_if.sink       key_in,
	mmh_out_if.source    hash_out
);

	logic [63:0] seed_q;
	logic [63:0] word_q;
	logic [3:0]  nb_q;
	logic [31:0] klen_q;
	logic        last_q;
	logic [63:0] h_q;
	logic [63:0] t_q;
	logic [63:0] acc_q;
	logic [63:0] hash_q;
	logic        out_valid_q;

	logic [63:0] operand;
	logic [31:0] a_part;
	logic [31:0] m_part;
	logic [63:0] prod;
	logic [63:0] result;
	logic        done;

	assign key_in.ready      = cmd.in_ready;
	assign hash_out.valid    = out_valid_q;
	assign hash_out.hash_value = hash_q;

	assign status.accept    = key_in.valid && key_in.ready;
	assign status.full_word = nb_q[3];
	assign status.has_tail  = (nb_q[2:0] != 3'd0);
	assign status.last      = last_q;
	assign status.out_busy  = out_valid_q;

	always_comb begin
		case (cmd.op)
			OP_LEN:  operand = {32'd0, klen_q};
			OP_W1:   operand = word_q;
			OP_W2:   operand = mix47(t_q);
			OP_W3:   operand = h_q;
			OP_TAIL: operand = h_q ^ (word_q & tail_mask(nb_q[2:0]));
			OP_FIN:  operand = mix47(h_q);
			default: operand = h_q;
		endcase
	end

	// The 64-bit product is built from three 32-bit partial products, one a cycle while step_en is high.
	assign a_part = (cmd.step == STEP_MID) ? operand[63:32] : operand[31:0];
	assign m_part = (cmd.step == STEP_TOP) ? MUL_HI : MUL_LO;
	assign prod   = {32'd0, a_part} * {32'd0, m_part};
	assign result = {acc_q[63:32] + prod[31:0], acc_q[31:0]};
	assign done   = cmd.step_en && (cmd.step == STEP_TOP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q      <= 64'd0;
			h_q         <= 64'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				seed_q <= cfg_wdata;
			end
			if (hash_out.valid && hash_out.ready) begin
				out_valid_q <= 1'b0;
			end
			if (done) begin
				case (cmd.op)
					OP_LEN:  h_q <= seed_q ^ result;
					OP_W2:   h_q <= h_q ^ result;
					OP_W3,
					OP_TAIL: h_q <= result;
					OP_FIN: begin
						h_q         <= 64'd0;
						out_valid_q <= 1'b1;
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			word_q <= key_in.data_word;
			nb_q   <= key_in.valid_bytes;
			klen_q <= key_in.key_length;
			last_q <= key_in.last_word;
		end
		if (cmd.step_en) begin
			if (cmd.step == STEP_LO) begin
				acc_q <= prod;
			end else if (cmd.step == STEP_MID) begin
				acc_q[63:32] <= acc_q[63:32] + prod[31:0];
			end
		end
		if (done && cmd.op == OP_W1) begin
			t_q <= result;
		end
		if (done && cmd.op == OP_FIN) begin
			hash_q <= mix47(result);
		end
	end

endmodule
